>>> hw/rtl/utf8d_pkg.sv
// utf8d_pkg: shared constants and types for the utf-8 to code point decoder
// no dependencies; imported by utf8d_core and utf8_to_code_point_decoder
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned RemW  = 2;

  // lead byte thresholds
  localparam logic [ByteW-1:0] Lead4Min = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Min = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Min = 8'hC0;

  // payload masks
  localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
  localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
  localparam logic [ByteW-1:0] ContMask  = 8'h3F;

  // bytes still expected after a lead
  localparam logic [RemW-1:0] RemNone = 2'd0;
  localparam logic [RemW-1:0] RemOne  = 2'd1;
  localparam logic [RemW-1:0] RemTwo  = 2'd2;
  localparam logic [RemW-1:0] RemThr  = 2'd3;

  // decode result handed from the core to the result register
  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic           last;
  } dec_result_t;

endpackage

>>> hw/rtl/utf8d_core.sv
// utf8d_core: sequence state and combinational decode of one byte
// depends on utf8d_pkg
module utf8d_core import utf8d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_byte_i,
  output dec_result_t      result_o
);

  logic [CpW-1:0]  acc_q, acc_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [CpW-1:0]  cont_bits;
  logic [CpW-1:0]  acc_next;

  // continuation payload placed at the position implied by bytes left
  always_comb begin
    unique case (rem_q)
      RemThr:  cont_bits = CpW'(data_byte_i & ContMask) << 12;
      RemTwo:  cont_bits = CpW'(data_byte_i & ContMask) << 6;
      RemOne:  cont_bits = CpW'(data_byte_i & ContMask);
      default: cont_bits = '0;
    endcase
  end

  always_comb begin
    acc_d    = acc_q;
    rem_d    = rem_q;
    acc_next = '0;
    result_o = '0;
    if (rem_q == RemNone) begin
      priority if (data_byte_i >= Lead4Min) begin
        acc_next = CpW'(data_byte_i & Lead4Mask) << 18;
        rem_d    = RemThr;
      end else if (data_byte_i >= Lead3Min) begin
        acc_next = CpW'(data_byte_i & Lead3Mask) << 12;
        rem_d    = RemTwo;
      end else if (data_byte_i >= Lead2Min) begin
        acc_next = CpW'(data_byte_i & Lead2Mask) << 6;
        rem_d    = RemOne;
      end else begin
        // plain or stray byte passes straight through
        acc_next            = CpW'(data_byte_i);
        result_o.emit       = 1'b1;
        result_o.code_point = acc_next;
        result_o.last       = last_byte_i;
      end
      acc_d = acc_next;
      if (rem_d != RemNone && last_byte_i) begin
        // truncated text: flush the partial lead
        result_o.emit       = 1'b1;
        result_o.code_point = acc_next;
        result_o.last       = 1'b1;
        rem_d               = RemNone;
        acc_d               = '0;
      end
    end else begin
      acc_next = acc_q | cont_bits;
      rem_d    = rem_q - RemOne;
      acc_d    = acc_next;
      if (rem_d == RemNone || last_byte_i) begin
        result_o.emit       = 1'b1;
        result_o.code_point = acc_next;
        result_o.last       = last_byte_i;
        rem_d               = RemNone;
        acc_d               = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= RemNone;
    end else if (step_i) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

endmodule

>>> hw/rtl/utf8_to_code_point_decoder.sv
// utf8_to_code_point_decoder: top level, input register, decode core and result register
// depends on utf8d_pkg and utf8d_core
//
// Streaming utf-8 decoder. One byte beat is taken on the slave side every cycle
// while the master side keeps up; a completed code point leaves as one beat on
// the master side once its last byte has passed the input and result registers.
// Throughput is one byte per cycle, set by the combinational decode step that
// sits between the input register and the result register; a stalled result
// holds in the result register while the input register still takes one more
// byte. A lead byte at or above 0xF0 opens a four byte sequence, at or above
// 0xE0 three bytes, at or above 0xC0 two bytes; every other byte, stray
// continuation bytes included, is passed out as its own code point. Bytes
// inside a sequence contribute their low six bits without a form check. A byte
// with tlast set that cuts a sequence short flushes the partial value (missing
// bits zero) with tlast set, and decoding restarts with the next byte.
module utf8_to_code_point_decoder import utf8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_axis_tlast    // last_item
);

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // result register
  logic             out_valid_q;
  logic [CpW-1:0]   out_cp_q;
  logic             out_last_q;

  logic             out_free;
  logic             step;
  dec_result_t      dec;

  // result register can take a new beat when empty or draining this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  // decode the held byte whenever its result has somewhere to go
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  utf8d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .result_o    (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && dec.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && dec.emit) begin
      out_cp_q   <= dec.code_point;
      out_last_q <= dec.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_cp_q};
  assign m_axis_tlast  = out_last_q;

endmodule

>>> hw/rtl/utf8d_checker.sv
// utf8d_checker: port-level assertions for utf8_to_code_point_decoder
// depends on nothing but the top level ports; bound to the top level below
module utf8d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // code point never exceeds 21 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:21] == 3'b000)
    else $error("code point padding not zero");

  // slave side only stalls behind a stalled master side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // a fresh result beat follows a byte beat accepted through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result beat without a matching byte beat");

endmodule

bind utf8_to_code_point_decoder utf8d_checker u_utf8d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
